/* hdl/tcc_pkg.sv */
// Shared types and constants for the torque converter coupling block.
// No dependencies; every other file in hdl/ depends on this package.
package tcc_pkg;

    localparam int unsigned SR_W   = 17;   // speed ratio, Q1.16
    localparam int unsigned TR_W   = 19;   // torque ratio / stall ratio, Q3.16
    localparam int unsigned CP_W   = 17;   // coupling point, Q1.16
    localparam int unsigned CC_W   = 32;   // capacity coefficient, Q0.32
    localparam int unsigned SPD_W  = 32;   // speeds, signed Q16.16
    localparam int unsigned CAP_W  = 48;   // capacity, Q32.16
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam int unsigned FRAC_W = 16;   // fraction bits of the speed ratio

    localparam logic [TR_W-1:0] ONE_Q16   = TR_W'(65536);
    localparam logic [TR_W-1:0] STALL_RST = TR_W'(131072);
    localparam logic [CP_W-1:0] COUPLE_RST = CP_W'(55706);
    localparam logic [CC_W-1:0] CAPCO_RST = CC_W'(17352);

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STALL  = 2'd0,
        CFG_COUPLE = 2'd1,
        CFG_CAPCO  = 2'd2
    } t_cfg_idx;

    // Sideband carried through the speed divider
    typedef struct packed {
        logic             ok;      // linked, both nonzero, same sign
        logic             clamp;   // |t| >= |p|, ratio saturates at one
        logic             lnk;
        logic [SPD_W-1:0] mref;    // max(|p|, |t|)
    } t_d1_side;

    // Sideband carried through the torque divider
    typedef struct packed {
        logic [SR_W-1:0] sr;
        logic            byp;      // torque ratio is exactly one
        logic            lnk;
        logic [32:0]     sr2;      // sr squared, at most 2^32
        logic [63:0]     m2;       // mref squared, Q32.32
    } t_d2_side;

endpackage

/* hdl/tcc_if.sv */
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on tcc_pkg for field widths.
interface tcc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tcc_pkg::SPD_W-1:0]     pump_speed;
    logic signed [tcc_pkg::SPD_W-1:0]     turbine_speed;
    logic                                 linked;
    modport source (output valid, pump_speed, turbine_speed, linked, input ready);
    modport sink   (input valid, pump_speed, turbine_speed, linked, output ready);
endinterface

interface tcc_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcc_pkg::SR_W-1:0]      speed_ratio;
    logic [tcc_pkg::TR_W-1:0]      torque_ratio;
    logic [tcc_pkg::CAP_W-1:0]     capacity;
    modport source (output valid, speed_ratio, torque_ratio, capacity, input ready);
    modport sink   (input valid, speed_ratio, torque_ratio, capacity, output ready);
endinterface

interface tcc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcc_pkg::CFG_IDX_W-1:0]     index;
    logic [tcc_pkg::CFG_DAT_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/torque_converter_coupling.sv */
// Top level of the torque converter coupling block: magnitudes, two dividers,
// multiplier stages. Depends on tcc_pkg, tcc_if and tcc_div.
//
// Usage:
//   i_in  carries pump_speed, turbine_speed (signed Q16.16) and linked.
//   o_out carries speed_ratio (Q1.16), torque_ratio (Q3.16), capacity (Q32.16).
//   i_cfg writes stall_ratio (index 0), coupling_point (1), capacity_coeff (2);
//   other indexes are dropped. It is always ready; write it only while idle.
//   The pipeline is 41 register stages deep: one input stage, 16 stages of the
//   speed-ratio divider (one quotient bit each), one multiply stage, 19 stages
//   of the torque-ratio divider, then four stages for the 64x64 capacity
//   product (coefficient scaling, partial products, two adds).
//   Throughput is one item per cycle unless the receiver stalls. Each result is one transfer.
//   Reset clears all valid bits and loads the default register values.
//   When the receiver stalls a valid result, the whole pipeline holds in place
//   and i_in.ready drops, even if bubbles sit in front of the stalled result;
//   nothing is lost or repeated.
module torque_converter_coupling (
    input  logic i_clk,
    input  logic i_rst_n,
    tcc_in_if.sink    i_in,
    tcc_cfg_if.sink   i_cfg,
    tcc_out_if.source o_out
);
    import tcc_pkg::*;

    localparam int unsigned SR_Q_W = FRAC_W;   // quotient bits of the speed divider
    localparam int unsigned NUM_W  = TR_W + SR_W;

    // Configuration registers
    logic [TR_W-1:0] r_stall;
    logic [CP_W-1:0] r_couple;
    logic [CC_W-1:0] r_capco;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall  <= STALL_RST;
            r_couple <= COUPLE_RST;
            r_capco  <= CAPCO_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_STALL:  r_stall  <= i_cfg.data[TR_W-1:0];
                CFG_COUPLE: r_couple <= i_cfg.data[CP_W-1:0];
                CFG_CAPCO:  r_capco  <= i_cfg.data[CC_W-1:0];
                default:    ;
            endcase
        end
    end

    // Global advance: move when the output register is empty or taken
    logic w_en;
    logic r_o_vld;
    assign w_en       = !r_o_vld || o_out.ready;
    assign i_in.ready = w_en;

    // Input stage: magnitudes and flags
    logic [SPD_W-1:0] w_pu, w_tu, w_pm, w_tm;
    t_d1_side         w_s0;
    logic             r0_vld;
    logic [SPD_W-1:0] r0_p, r0_t;
    t_d1_side         r0_side;

    assign w_pu = unsigned'(i_in.pump_speed);
    assign w_tu = unsigned'(i_in.turbine_speed);
    assign w_pm = w_pu[SPD_W-1] ? (~w_pu + 1'b1) : w_pu;
    assign w_tm = w_tu[SPD_W-1] ? (~w_tu + 1'b1) : w_tu;

    always_comb begin
        w_s0.lnk   = i_in.linked;
        w_s0.ok    = i_in.linked && (w_pm != '0) && (w_tm != '0)
                     && (w_pu[SPD_W-1] == w_tu[SPD_W-1]);
        w_s0.clamp = (w_tm >= w_pm);
        w_s0.mref  = (w_pm > w_tm) ? w_pm : w_tm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_p    <= w_pm;
            r0_t    <= w_tm;
            r0_side <= w_s0;
        end
    end

    // Speed ratio divider: floor(|t| * 2^16 / |p|) for |t| < |p|
    logic                        w_d1_vld;
    logic [SR_Q_W-1:0]           w_d1_quo;
    logic [$bits(t_d1_side)-1:0] w_d1_side_v;
    t_d1_side                    w_d1_side;

    tcc_div #(
        .DEN_W (SPD_W),
        .Q_W   (SR_Q_W),
        .SIDE_W($bits(t_d1_side))
    ) u_div_sr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r0_vld),
        .i_rem  (r0_t),
        .i_low  ('0),
        .i_den  (r0_p),
        .i_side (r0_side),
        .o_vld  (w_d1_vld),
        .o_quo  (w_d1_quo),
        .o_side (w_d1_side_v)
    );
    assign w_d1_side = t_d1_side'(w_d1_side_v);

    // Multiply stage: torque numerator, sr^2, mref^2
    logic            w_sge;
    logic [TR_W-1:0] w_diff;
    logic [SR_W-1:0] w_sr;
    t_d2_side        w_s2;
    logic            rT_vld;
    logic [NUM_W-1:0] rT_num;
    t_d2_side        rT_side;
    logic [2*SR_W-1:0] w_sr2_full;

    assign w_sge  = (r_stall >= ONE_Q16);
    assign w_diff = w_sge ? (r_stall - ONE_Q16) : (ONE_Q16 - r_stall);
    assign w_sr   = !w_d1_side.ok   ? '0 :
                    w_d1_side.clamp ? ONE_Q16[SR_W-1:0] : {1'b0, w_d1_quo};
    assign w_sr2_full = w_sr * w_sr;

    always_comb begin
        w_s2.sr  = w_sr;
        w_s2.byp = (r_couple == '0) || (w_sr >= r_couple);
        w_s2.lnk = w_d1_side.lnk;
        w_s2.sr2 = w_sr2_full[32:0];
        w_s2.m2  = w_d1_side.mref * w_d1_side.mref;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rT_vld <= 1'b0;
        end else if (w_en) begin
            rT_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rT_num  <= w_diff * w_sr;
            rT_side <= w_s2;
        end
    end

    // Torque divider: floor(diff * sr / coupling_point), below 2^19
    logic                        w_d2_vld;
    logic [TR_W-1:0]             w_d2_quo;
    logic [$bits(t_d2_side)-1:0] w_d2_side_v;
    t_d2_side                    w_d2_side;

    tcc_div #(
        .DEN_W (CP_W),
        .Q_W   (TR_W),
        .SIDE_W($bits(t_d2_side))
    ) u_div_tr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (rT_vld),
        .i_rem  (rT_num[NUM_W-1:TR_W]),
        .i_low  (rT_num[TR_W-1:0]),
        .i_den  (r_couple),
        .i_side (rT_side),
        .o_vld  (w_d2_vld),
        .o_quo  (w_d2_quo),
        .o_side (w_d2_side_v)
    );
    assign w_d2_side = t_d2_side'(w_d2_side_v);

    // Coefficient stage: torque ratio and k = coeff * (2^32 - sr^2)
    logic [32:0]     w_d;
    logic            rK_vld, rK_lnk;
    logic [63:0]     rK_k, rK_m2;
    logic [SR_W-1:0] rK_sr;
    logic [TR_W-1:0] rK_tr;

    assign w_d = 33'h1_0000_0000 - w_d2_side.sr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rK_vld <= 1'b0;
        end else if (w_en) begin
            rK_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rK_lnk <= w_d2_side.lnk;
            rK_sr  <= w_d2_side.sr;
            rK_m2  <= w_d2_side.m2;
            rK_tr  <= w_d2_side.byp ? ONE_Q16 :
                      w_sge ? (r_stall - w_d2_quo) : (r_stall + w_d2_quo);
            rK_k   <= w_d[32] ? {r_capco, 32'b0} : (64'(r_capco) * 64'(w_d[31:0]));
        end
    end

    // Partial products of k * m2
    logic            rP_vld, rP_lnk;
    logic [63:0]     rP_00, rP_01, rP_10, rP_11;
    logic [SR_W-1:0] rP_sr;
    logic [TR_W-1:0] rP_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP_vld <= 1'b0;
        end else if (w_en) begin
            rP_vld <= rK_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rP_00  <= rK_k[31:0]  * rK_m2[31:0];
            rP_01  <= rK_k[31:0]  * rK_m2[63:32];
            rP_10  <= rK_k[63:32] * rK_m2[31:0];
            rP_11  <= rK_k[63:32] * rK_m2[63:32];
            rP_lnk <= rK_lnk;
            rP_sr  <= rK_sr;
            rP_tr  <= rK_tr;
        end
    end

    // Combine the cross terms; outer terms do not overlap
    logic            rA_vld, rA_lnk;
    logic [127:0]    rA_w;
    logic [64:0]     rA_mid;
    logic [SR_W-1:0] rA_sr;
    logic [TR_W-1:0] rA_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_vld <= 1'b0;
        end else if (w_en) begin
            rA_vld <= rP_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rA_w   <= {rP_11, rP_00};
            rA_mid <= {1'b0, rP_01} + {1'b0, rP_10};
            rA_lnk <= rP_lnk;
            rA_sr  <= rP_sr;
            rA_tr  <= rP_tr;
        end
    end

    // Output register: final sum, shift to Q32.16
    logic [127:0]     w_sum;
    logic             r_o_lnk;
    logic [SR_W-1:0]  r_o_sr;
    logic [TR_W-1:0]  r_o_tr;
    logic [CAP_W-1:0] r_o_cap;

    assign w_sum = rA_w + {31'b0, rA_mid, 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= rA_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_lnk <= rA_lnk;
            r_o_sr  <= rA_sr;
            r_o_tr  <= rA_tr;
            r_o_cap <= rA_lnk ? w_sum[127:80] : '0;
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.speed_ratio  = r_o_sr;
    assign o_out.torque_ratio = r_o_tr;
    assign o_out.capacity     = r_o_cap;

`ifndef SYNTHESIS
    // Speed ratio never exceeds one
    a_sr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_sr <= ONE_Q16[SR_W-1:0]))
        else $error("speed ratio above one");

    // Unlinked items give zero ratio and zero capacity
    a_unlinked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_o_lnk) |-> (r_o_sr == '0 && r_o_cap == '0))
        else $error("unlinked item with nonzero result");

    // A stalled result holds its place while input is refused
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !o_out.ready) |=> (r_o_vld && $stable(r_o_tr)))
        else $error("stalled result changed");
`endif

endmodule

/* hdl/tcc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on tcc_pkg; all widths come in as parameters.
module tcc_div #(
    parameter int unsigned DEN_W  = 32,
    parameter int unsigned Q_W    = 16,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [DEN_W-1:0]  i_rem,    // upper dividend part, below i_den
    input  logic [Q_W-1:0]    i_low,    // dividend bits shifted in, MSB first
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);
    import tcc_pkg::*;

    logic [Q_W-1:0]    r_vld;
    logic [DEN_W-1:0]  r_rem  [Q_W];
    logic [Q_W-1:0]    r_low  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic              w_vld;
        logic [DEN_W-1:0]  w_rem;
        logic [Q_W-1:0]    w_low;
        logic [Q_W-1:0]    w_quo;
        logic [DEN_W-1:0]  w_den;
        logic [SIDE_W-1:0] w_side;
        logic [DEN_W:0]    w_shf;
        logic [DEN_W:0]    w_dif;
        logic              w_ge;

        if (g == 0) begin : g_head
            assign w_vld  = i_vld;
            assign w_rem  = i_rem;
            assign w_low  = i_low;
            assign w_quo  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_low  = r_low[g-1];
            assign w_quo  = r_quo[g-1];
            assign w_den  = r_den[g-1];
            assign w_side = r_side[g-1];
        end

        // Shift in one dividend bit, subtract when it fits
        assign w_shf = {w_rem, w_low[Q_W-1]};
        assign w_dif = w_shf - {1'b0, w_den};
        assign w_ge  = (w_shf >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? w_dif[DEN_W-1:0] : w_shf[DEN_W-1:0];
                r_low[g]  <= {w_low[Q_W-2:0], 1'b0};
                r_quo[g]  <= {w_quo[Q_W-2:0], w_ge};
                r_den[g]  <= w_den;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_quo[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule
